>>> sv/free_list_page_allocator_core_assert.svh
// assertion macros shared by the page allocator rtl
// no dependencies; included inside module bodies after the package import
`ifndef FREE_LIST_PAGE_ALLOCATOR_CORE_ASSERT_SVH
`define FREE_LIST_PAGE_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication
`define FPA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FPA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/fpa_pkg.sv
// shared types and constants of the free-list page allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fpa_pkg;

   localparam int unsigned NUM_PAGES_DEF = 65536;

   localparam int unsigned PAGE_SHIFT = 12;
   localparam int unsigned ADDR_W     = 28;  // byte address
   localparam int unsigned LEN_W      = 29;  // byte length, kernel end
   localparam int unsigned TOP_W      = 30;  // base + length
   localparam int unsigned HEAD_W     = 16;  // list head and link width
   localparam int unsigned TOTAL_W    = 17;  // free page count
   localparam int unsigned AFW        = 18;  // frame number while walking a region
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 29;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   localparam logic [CSR_IDX_W-1:0] CSR_KSTART = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEND   = 1'b1;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_ALLOC = 2'd1,
      OP_FREE  = 2'd2,
      OP_NOP   = 2'd3
   } fpa_op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_RANGE = 2'd2
   } fpa_status_type;

   // region walker to list control
   typedef struct packed {
      logic           push;
      logic           done;
      logic           range_err;
      logic [AFW-1:0] frame;
   } fpa_walk_type;

endpackage

`default_nettype wire

>>> sv/fpa_ram.sv
// generic simple dual-port ram, registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module fpa_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

>>> sv/fpa_region_walker.sv
// region walker: clips a memory-map region against the kernel range
// and steps through its whole pages, one push per cycle; uses fpa_pkg
`timescale 1ns / 1ps
`default_nettype none

module fpa_region_walker #(
   parameter int unsigned NUM_PAGES = fpa_pkg::NUM_PAGES_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [fpa_pkg::ADDR_W-1:0]   base,
   input  wire logic [fpa_pkg::LEN_W-1:0]    length,
   input  wire logic [fpa_pkg::HEAD_W-1:0]   kstart_pg,
   input  wire logic [fpa_pkg::AFW-1:0]      kend_pg,
   output fpa_pkg::fpa_walk_type             walk
);
   import fpa_pkg::*;

   typedef enum logic [2:0] {
      W_IDLE = 3'b001,
      W_BASE = 3'b010,
      W_LOOP = 3'b100
   } walk_state_type;

   walk_state_type state_ff, state_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [TOP_W-1:0]  top_ff, top_in;
   logic [AFW-1:0]    cur_ff, cur_in;
   logic [AFW-1:0]    end_ff, end_in;

   logic overlap;
   logic [LEN_W-1:0] base_up;

   always_comb begin
      state_in = state_ff;
      base_in  = base_ff;
      top_in   = top_ff;
      cur_in   = cur_ff;
      end_in   = end_ff;
      walk     = '0;
      overlap  = (TOP_W'(base_ff) < {kend_pg, 12'h000})
               && (top_ff > TOP_W'({kstart_pg, 12'h000}));
      base_up  = LEN_W'(base_ff) + LEN_W'(12'hFFF);
      case (state_ff)
         W_IDLE: begin
            if (start) begin
               base_in  = base;
               top_in   = TOP_W'(base) + TOP_W'(length);
               state_in = W_BASE;
            end
         end
         W_BASE: begin
            // raised base is already page aligned
            cur_in   = overlap ? kend_pg : AFW'(base_up[LEN_W-1:PAGE_SHIFT]);
            end_in   = top_ff[TOP_W-1:PAGE_SHIFT];
            state_in = W_LOOP;
         end
         W_LOOP: begin
            walk.frame = cur_ff;
            if (cur_ff >= end_ff) begin
               walk.done = 1'b1;
               state_in  = W_IDLE;
            end else if (cur_ff == '0) begin
               cur_in = cur_ff + AFW'(1);
            end else if (32'(cur_ff) >= NUM_PAGES) begin
               walk.done      = 1'b1;
               walk.range_err = 1'b1;
               state_in       = W_IDLE;
            end else begin
               walk.push = 1'b1;
               cur_in    = cur_ff + AFW'(1);
            end
         end
         default: begin
            state_in = W_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= W_IDLE;
      end else begin
         state_ff <= state_in;
      end
      base_ff <= base_in;
      top_ff  <= top_in;
      cur_ff  <= cur_in;
      end_ff  <= end_in;
   end

endmodule

`default_nettype wire

>>> sv/free_list_page_allocator_core.sv
// top level of the free-list page allocator: list control, kernel range
// registers, next-frame ram; uses fpa_pkg, fpa_ram, fpa_region_walker
//
// usage
//  - a request is taken on a rising edge with start high and busy low; the
//    opcode selects add region, allocate or free, the other fields are its
//    operands
//  - each request gives exactly one response: rsp_valid is high for one
//    cycle with rsp_status, rsp_page_address and rsp_free_pages; there is
//    no back-pressure, the receiver must take it in that cycle
//  - kernel_start and kernel_end are written through csr_we / csr_index /
//    csr_wdata while no request is in flight; they are stored page aligned
// timing
//  - free, unknown opcode, unusable region and allocate on an empty list:
//    response registered at the edge that takes the request, busy stays low
//  - allocate: busy in S_ALLOC, which waits for the registered read of the
//    next-frame ram (head is read, its link becomes the new head)
//  - add region: the walker passes W_BASE, then in W_LOOP pushes one frame
//    per cycle through the ram write port, skipping frame zero; busy stays high
//  - requests run one at a time, so a ram read never meets a pending write
// reset
//  - synchronous, active high: empty list, zero count, kernel range zero;
//    the ram is not cleared, a link is only read after it was written
`timescale 1ns / 1ps
`default_nettype none

module free_list_page_allocator_core #(
   parameter int unsigned NUM_PAGES = fpa_pkg::NUM_PAGES_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [1:0]                      req_opcode,
   input  wire logic [fpa_pkg::ADDR_W-1:0]      req_region_base,
   input  wire logic [fpa_pkg::LEN_W-1:0]       req_region_length,
   input  wire logic                            req_region_usable,
   input  wire logic [fpa_pkg::ADDR_W-1:0]      req_free_address,
   // response channel
   output logic                                 rsp_valid,
   output logic [1:0]                           rsp_status,
   output logic [fpa_pkg::ADDR_W-1:0]           rsp_page_address,
   output logic [fpa_pkg::TOTAL_W-1:0]          rsp_free_pages,
   // configuration write port
   input  wire logic                            csr_we,
   input  wire logic [fpa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [fpa_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import fpa_pkg::*;
   `include "free_list_page_allocator_core_assert.svh"

   localparam int unsigned FW = $clog2(NUM_PAGES);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_ALLOC = 3'b010,
      S_ADD   = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // list state
   logic [HEAD_W-1:0]  head_ff, head_in;
   logic [TOTAL_W-1:0] total_ff, total_in;

   // kernel range, page numbers
   logic [HEAD_W-1:0] kstart_pg_ff, kstart_pg_in;
   logic [AFW-1:0]    kend_pg_ff, kend_pg_in;
   logic [TOP_W-1:0]  kend_up;

   // response registers
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]   rsp_page_ff, rsp_page_in;

   // ram and walker hookup
   logic              push_valid;
   logic [HEAD_W-1:0] push_frame;
   logic [FW-1:0]     push_addr;
   logic              rd_en;
   logic [HEAD_W-1:0] rd_data;
   logic              walk_start;
   fpa_walk_type      walk;

   logic [HEAD_W-1:0] free_frame;
   logic              head_ok;

   fpa_ram #(
      .WIDTH (HEAD_W),
      .DEPTH (NUM_PAGES)
   ) u_next_frame (
      .clock (clock),
      .we    (push_valid),
      .waddr (push_addr),
      .wdata (head_ff),
      .re    (rd_en),
      .raddr (FW'(head_ff)),
      .rdata (rd_data)
   );

   fpa_region_walker #(
      .NUM_PAGES (NUM_PAGES)
   ) u_walker (
      .clock     (clock),
      .reset     (reset),
      .start     (walk_start),
      .base      (req_region_base),
      .length    (req_region_length),
      .kstart_pg (kstart_pg_ff),
      .kend_pg   (kend_pg_ff),
      .walk      (walk)
   );

   // configuration: keep kernel range as page numbers, end rounded up
   always_comb begin
      kstart_pg_in = kstart_pg_ff;
      kend_pg_in   = kend_pg_ff;
      kend_up      = TOP_W'(csr_wdata) + TOP_W'(12'hFFF);
      if (csr_we) begin
         case (csr_index)
            CSR_KSTART: begin
               kstart_pg_in = csr_wdata[ADDR_W-1:PAGE_SHIFT];
            end
            CSR_KEND: begin
               kend_pg_in = kend_up[TOP_W-1:PAGE_SHIFT];
            end
            default: begin
               kstart_pg_in = kstart_pg_ff;
            end
         endcase
      end
   end

   // request sequencing and list update
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      total_in      = total_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_OK;
      rsp_page_in   = '0;
      push_valid    = 1'b0;
      push_frame    = '0;
      push_addr     = '0;
      rd_en         = 1'b0;
      walk_start    = 1'b0;
      free_frame    = req_free_address[ADDR_W-1:PAGE_SHIFT];
      head_ok       = (head_ff != '0) && (32'(head_ff) < NUM_PAGES);

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (fpa_op_type'(req_opcode))
                  OP_ADD: begin
                     if (req_region_usable) begin
                        walk_start = 1'b1;
                        state_in   = S_ADD;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  OP_ALLOC: begin
                     if (head_ok) begin
                        // fetch the link below the head
                        rd_en    = 1'b1;
                        state_in = S_ALLOC;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_EMPTY;
                     end
                  end
                  OP_FREE: begin
                     rsp_valid_in = 1'b1;
                     // page zero is silently ignored
                     if (free_frame != '0) begin
                        if (32'(free_frame) >= NUM_PAGES) begin
                           rsp_status_in = ST_RANGE;
                        end else begin
                           push_valid = 1'b1;
                           push_frame = free_frame;
                           push_addr  = FW'(free_frame);
                        end
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_ALLOC: begin
            head_in      = rd_data;
            rsp_valid_in = 1'b1;
            rsp_page_in  = {head_ff, 12'h000};
            if (total_ff != '0) begin
               total_in = total_ff - TOTAL_W'(1);
            end
            state_in = S_IDLE;
         end
         S_ADD: begin
            if (walk.push) begin
               push_valid = 1'b1;
               push_frame = walk.frame[HEAD_W-1:0];
               push_addr  = FW'(walk.frame);
            end
            if (walk.done) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = walk.range_err ? ST_RANGE : ST_OK;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // push: old head goes to the ram link, new frame becomes head
      if (push_valid) begin
         head_in = push_frame;
         if (total_ff != TOTAL_MAX) begin
            total_in = total_ff + TOTAL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         total_ff     <= '0;
         kstart_pg_ff <= '0;
         kend_pg_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         total_ff     <= total_in;
         kstart_pg_ff <= kstart_pg_in;
         kend_pg_ff   <= kend_pg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_page_ff   <= rsp_page_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_page_address = rsp_page_ff;
   // count register is updated at the same edge the response is raised
   assign rsp_free_pages   = total_ff;

   `FPA_ASSERT_NEXT(a_req_progress, clock, reset, start && !busy, rsp_valid || busy, "request neither answered nor in progress")
   `FPA_ASSERT_NEXT(a_alloc_two_cycles, clock, reset, state_ff == S_ALLOC, rsp_valid && !busy, "allocate did not finish after the ram read")
   `FPA_ASSERT_NOW(a_fail_no_page, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_page_address == '0, "page address on a failed response")
   `FPA_ASSERT_NOW(a_walk_push_in_add, clock, reset, walk.push || walk.done, state_ff == S_ADD, "region walker active outside add")

endmodule

`default_nettype wire

>>> tb/testbench.sv
// self-checking testbench for free_list_page_allocator_core: directed and random
// requests, all checked against a predictor of the free list; needs fpa_pkg and the rtl
`timescale 1ns / 1ps

module testbench;
   import fpa_pkg::*;

   localparam int unsigned     NUM_PAGES  = NUM_PAGES_DEF;
   localparam longint unsigned PAGE_BYTES = 4096;
   localparam longint unsigned PAGE_MASK  = 64'hFFF;
   localparam int unsigned     TIMEOUT_NS = 20_000_000;

   // one response as the block should give it
   typedef struct {
      fpa_status_type          status;
      logic [ADDR_W-1:0]       page_address;
      logic [TOTAL_W-1:0]      free_pages;
   } page_response_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [1:0]              req_opcode = '0;
   logic [ADDR_W-1:0]       req_region_base = '0;
   logic [LEN_W-1:0]        req_region_length = '0;
   logic                    req_region_usable = 1'b0;
   logic [ADDR_W-1:0]       req_free_address = '0;
   logic                    rsp_valid;
   logic [1:0]              rsp_status;
   logic [ADDR_W-1:0]       rsp_page_address;
   logic [TOTAL_W-1:0]      rsp_free_pages;
   logic                    csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   free_list_page_allocator_core #(
      .NUM_PAGES(NUM_PAGES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_opcode(req_opcode),
      .req_region_base(req_region_base),
      .req_region_length(req_region_length),
      .req_region_usable(req_region_usable),
      .req_free_address(req_free_address),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_page_address(rsp_page_address),
      .rsp_free_pages(rsp_free_pages),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // predicted allocator state: kernel range, list head, free count, links
   logic [ADDR_W-1:0]   kstart_q = '0;
   logic [LEN_W-1:0]    kend_q = '0;
   logic [HEAD_W-1:0]   head_q = '0;
   logic [TOTAL_W-1:0]  total_q = '0;
   logic [HEAD_W-1:0]   link_q [NUM_PAGES];

   page_response_type   pending_responses [$];
   page_response_type   last_response;
   page_response_type   oldest;
   logic [ADDR_W-1:0]   held_pages [$];       // pages handed out and not yet freed
   longint unsigned     region_cursor;        // fresh regions of the random traffic start above this
   int                  error_count = 0;
   int                  checked_count = 0;
   int                  op_count [4] = '{0, 0, 0, 0};
   int                  empty_count = 0;
   int                  range_count = 0;

   // ---------------------------------------------------------------- predictor

   function automatic void push_frame(input logic [HEAD_W-1:0] frame);
      link_q[frame] = head_q;
      head_q = frame;
      if (total_q != TOTAL_MAX) total_q++;
   endfunction

   // push every whole page of a region, kernel range cut away, bottom up
   function automatic fpa_status_type add_region(input longint unsigned base,
                                                 input longint unsigned length,
                                                 input logic usable);
      longint unsigned kst;
      longint unsigned kend;
      longint unsigned top;
      longint unsigned page;
      longint unsigned frame;
      fpa_status_type  status;
      kst = longint'(kstart_q) & ~PAGE_MASK;
      kend = (longint'(kend_q) + PAGE_MASK) & ~PAGE_MASK;
      top = base + length;
      status = ST_OK;
      if (!usable) return ST_OK;
      if (base < kend && top > kst) base = kend;
      if (base >= top) return ST_OK;
      base = (base + PAGE_MASK) & ~PAGE_MASK;
      top = top & ~PAGE_MASK;
      // the walk stops at the first frame beyond the store
      for (page = base; page < top && status == ST_OK; page += PAGE_BYTES) begin
         frame = page / PAGE_BYTES;
         if (frame >= NUM_PAGES) status = ST_RANGE;
         else if (frame != 0) push_frame(frame[HEAD_W-1:0]);
      end
      return status;
   endfunction

   function automatic page_response_type predict_response(input fpa_op_type op,
                                                          input logic [ADDR_W-1:0] base,
                                                          input logic [LEN_W-1:0] len,
                                                          input logic usable,
                                                          input logic [ADDR_W-1:0] faddr);
      page_response_type r;
      logic [HEAD_W-1:0] frame;
      r.status = ST_OK;
      r.page_address = '0;
      case (op)
         OP_ADD: r.status = add_region(base, len, usable);
         OP_ALLOC: begin
            if (head_q == 0 || head_q >= NUM_PAGES) begin
               r.status = ST_EMPTY;
            end else begin
               r.page_address = {head_q, 12'h000};
               head_q = link_q[head_q];
               if (total_q != 0) total_q--;
            end
         end
         OP_FREE: begin
            // page 0 is silently ignored
            frame = faddr[ADDR_W-1:PAGE_SHIFT];
            if (frame != 0) begin
               if (frame >= NUM_PAGES) r.status = ST_RANGE;
               else push_frame(frame);
            end
         end
         default: ;
      endcase
      r.free_pages = total_q;
      return r;
   endfunction

   // ---------------------------------------------------------------- response check

   // every strobed response is matched against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_responses.size() == 0) begin
            $error("response with no request outstanding");
            error_count++;
         end else begin
            oldest = pending_responses.pop_front();
            checked_count++;
            if (rsp_status !== oldest.status) begin
               $error("rsp_status: expected %0d, got %0d", oldest.status, rsp_status);
               error_count++;
            end
            if (rsp_page_address !== oldest.page_address) begin
               $error("rsp_page_address: expected %h, got %h",
                      oldest.page_address, rsp_page_address);
               error_count++;
            end
            if (rsp_free_pages !== oldest.free_pages) begin
               $error("rsp_free_pages: expected %0d, got %0d",
                      oldest.free_pages, rsp_free_pages);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- drivers

   // present one request and hold it until taken; start stays high on return,
   // the caller either sends the next request or goes idle in the same step
   task automatic send_request(input fpa_op_type op,
                               input logic [ADDR_W-1:0] base,
                               input logic [LEN_W-1:0] len,
                               input logic usable,
                               input logic [ADDR_W-1:0] faddr);
      start <= 1'b1;
      req_opcode <= op;
      req_region_base <= base;
      req_region_length <= len;
      req_region_usable <= usable;
      req_free_address <= faddr;
      @(posedge clock);
      while (busy) @(posedge clock);
      last_response = predict_response(op, base, len, usable, faddr);
      pending_responses.push_back(last_response);
      op_count[op]++;
      if (last_response.status == ST_EMPTY) empty_count++;
      if (last_response.status == ST_RANGE) range_count++;
   endtask

   // unused operand fields carry random values
   task automatic send_add(input logic [ADDR_W-1:0] base, input logic [LEN_W-1:0] len,
                           input logic usable);
      send_request(OP_ADD, base, len, usable, $urandom);
   endtask

   task automatic send_alloc();
      send_request(OP_ALLOC, $urandom, $urandom_range(0, 32'h1000_0000), $urandom, $urandom);
   endtask

   task automatic send_free(input logic [ADDR_W-1:0] faddr);
      send_request(OP_FREE, $urandom, $urandom_range(0, 32'h1000_0000), $urandom, faddr);
   endtask

   task automatic idle_cycles(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // stop sending and wait for every predicted response
   task automatic wait_responses();
      start <= 1'b0;
      do @(posedge clock); while (pending_responses.size() != 0);
   endtask

   // register writes only while nothing is in flight
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      wait_responses();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_KSTART) kstart_q = value[ADDR_W-1:0];
      else kend_q = value[LEN_W-1:0];
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_empty_list_and_ignored();
      send_alloc();                                // empty list
      send_request(OP_NOP, $urandom, $urandom_range(0, 32'h1000_0000), $urandom, $urandom);
      send_free(28'h000_0ABC);                     // page 0 ignored
      send_free(28'hFFF_FFFF);                     // highest frame
      send_alloc();
      send_alloc();                                // empty again
      send_add(28'hFFF_FFFF, 29'h1000_0000, 1'b0); // unusable, highest base
   endtask

   task automatic test_region_alignment();
      send_add(28'h000_0000, 29'h0000_3800, 1'b1); // frame 0 skipped, 1 and 2 pushed
      send_add(28'h000_5800, 29'h0000_0800, 1'b1); // less than a page after alignment
      send_add(28'h000_7000, 29'h0000_0000, 1'b1); // zero length
      send_add(28'h000_8001, 29'h0000_2FFF, 1'b1); // unaligned base and length
      send_add(28'hFFF_E000, 29'h0000_4000, 1'b1); // runs past the store
      send_alloc();                                // last pushed comes out first
      send_alloc();
   endtask

   task automatic test_kernel_range();
      // kernel occupies pages 0x12 to 0x15 once aligned
      write_csr(CSR_KSTART, 29'h001_2345);
      write_csr(CSR_KEND, 29'h001_5001);
      send_add(28'h001_3000, 29'h0000_1000, 1'b1); // wholly inside, skipped
      send_add(28'h001_0000, 29'h0000_4000, 1'b1); // ends inside, nothing left
      send_add(28'h001_1000, 29'h0000_1000, 1'b1); // ends at kernel start
      send_add(28'h001_5800, 29'h0000_2800, 1'b1); // raised to aligned end
      send_add(28'h001_8000, 29'h0000_1000, 1'b1); // above the kernel
      // inverted range at the extremes: nothing overlaps
      write_csr(CSR_KSTART, 29'h0FFF_FFFF);
      write_csr(CSR_KEND, 29'h0000_0000);
      send_add(28'h002_0000, 29'h0000_1000, 1'b1);
      // kernel covers all memory: every region base is raised to the top
      write_csr(CSR_KSTART, 29'h0000_0000);
      write_csr(CSR_KEND, 29'h1000_0000);
      send_add(28'h002_1000, 29'h0000_1000, 1'b1);
      send_add(28'hFFF_F000, 29'h1000_0000, 1'b1);
      write_csr(CSR_KEND, 29'h0000_0000);
   endtask

   // mostly well-formed traffic: fresh regions from a rising cursor, allocations,
   // and frees of pages that are out; a tenth is noise that pushes nothing
   task automatic test_random_traffic(input int n, input int idle_pct);
      int                gap;
      int                kind;
      int                idx;
      longint unsigned   base_l;
      longint unsigned   kst_al;
      longint unsigned   kend_al;
      logic [LEN_W-1:0]  len;
      logic [ADDR_W-1:0] addr;
      // kernel just ahead of the cursor so regions run into it
      base_l = region_cursor + $urandom_range(32'h2000, 32'h2_0000);
      write_csr(CSR_KSTART, base_l[CSR_DATA_W-1:0]);
      base_l = base_l + $urandom_range(0, 32'h1_0000);
      write_csr(CSR_KEND, base_l[CSR_DATA_W-1:0]);
      kst_al = longint'(kstart_q) & ~PAGE_MASK;
      kend_al = (longint'(kend_q) + PAGE_MASK) & ~PAGE_MASK;
      for (int i = 0; i < n; i++) begin
         gap = 0;
         while ($urandom_range(0, 99) < idle_pct) gap++;
         idle_cycles(gap);
         // sender holds off until the block has answered everything
         if (i == n / 2 || $urandom_range(0, 99) == 0) wait_responses();
         kind = $urandom_range(0, 99);
         if (kind < 30) begin
            base_l = region_cursor + $urandom_range(0, 32'h1FFF);
            len = $urandom_range(0, 32'h6000);
            region_cursor = base_l + len + $urandom_range(0, 32'h2000);
            send_add(base_l[ADDR_W-1:0], len, 1'b1);
         end else if (kind < 60 || (kind < 90 && held_pages.size() == 0)) begin
            send_alloc();
            if (last_response.status == ST_OK) held_pages.push_back(last_response.page_address);
         end else if (kind < 90) begin
            idx = $urandom_range(0, held_pages.size() - 1);
            addr = held_pages[idx] | ADDR_W'($urandom_range(0, 32'hFFF));
            held_pages.delete(idx);
            send_free(addr);
         end else begin
            case ($urandom_range(0, 4))
               0: send_add($urandom, $urandom_range(0, 32'h1000_0000), 1'b0);
               1: send_request(OP_NOP, $urandom, $urandom_range(0, 32'h1000_0000),
                               $urandom, $urandom);
               2: send_free(ADDR_W'($urandom_range(0, 32'hFFF)));
               3: begin
                  // rounds up to the first frame beyond the store
                  base_l = $urandom_range(32'hFFF_F001, 32'hFFF_FFFF);
                  send_add(base_l[ADDR_W-1:0], $urandom_range(32'h2000, 32'h1000_0000), 1'b1);
               end
               default: begin
                  // wholly inside the kernel range
                  if (kend_al > kst_al) begin
                     base_l = $urandom_range(kst_al, kend_al - 1);
                     send_add(base_l[ADDR_W-1:0], $urandom_range(0, kend_al - base_l), 1'b1);
                  end else begin
                     send_add($urandom, $urandom_range(0, 32'h1000_0000), 1'b0);
                  end
               end
            endcase
         end
      end
   endtask

   // count saturation at both ends; leaves the list cyclic, so it runs last
   task automatic test_count_limits();
      write_csr(CSR_KSTART, 29'h0000_0000);
      write_csr(CSR_KEND, 29'h0000_0000);
      while (head_q != 0) send_alloc();
      send_alloc();
      // double free links the frame to itself; count then runs below the list
      send_free(28'h000_5ABC);
      send_free(28'h000_5123);
      repeat (3) send_alloc();
      // three full-memory adds push past the count ceiling
      repeat (3) send_add(28'h000_0000, 29'h1000_0000, 1'b1);
      send_free(28'hABC_D000);
      send_alloc();
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      region_cursor = $urandom_range(32'h0010_0000, 32'h0F00_0000);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_empty_list_and_ignored();
      test_region_alignment();
      test_kernel_range();
      test_random_traffic(300, 21);
      test_random_traffic(300, 74);
      test_random_traffic(300, 0);
      test_count_limits();
      wait_responses();
      repeat (20) @(posedge clock);
      $display("testbench: %0d requests (add %0d, alloc %0d, free %0d, nop %0d), %0d checked",
               op_count[0] + op_count[1] + op_count[2] + op_count[3], op_count[0],
               op_count[1], op_count[2], op_count[3], checked_count);
      $display("testbench: %0d empty-list answers, %0d out-of-store answers, %0d mismatches",
               empty_count, range_count, error_count);
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   // hang guard
   initial begin
      #(TIMEOUT_NS);
      $display("testbench: done, errors");
      $finish;
   end

endmodule
